@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ffgm_pkg.sv @@
package ffgm_pkg;

  // Frame geometry and pixel depth.
  localparam int FRAME_WIDTH  = 1280;
  localparam int FRAME_HEIGHT = 960;
  localparam int PIXEL_BITS   = 16;

  // Field widths.
  localparam int COL_W  = 11;
  localparam int ROW_W  = 10;
  localparam int PIX_W  = 16;
  localparam int CFG_W  = 11;
  localparam int GAIN_W = 32;

  // Accumulator and average widths; the average is Q.8.
  localparam int SUM_W    = 38;
  localparam int AVG_W    = 24;
  localparam int AVG_FRAC = 8;

  // Divider widths: the dividend holds the sum shifted by the fraction bits,
  // the divisor holds the zone area (11 by 10 bits of extent).
  localparam int DVD_W  = SUM_W + AVG_FRAC;
  localparam int AREA_W = COL_W + ROW_W;
  localparam int QUO_W  = GAIN_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  localparam logic [CNT_W-1:0] DIV_STEPS_AVG  = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] DIV_STEPS_GAIN = CNT_W'(GAIN_W);

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  // Register reset values.
  localparam logic [COL_W-1:0] LEFT_RST   = COL_W'(FRAME_WIDTH / 10);
  localparam logic [ROW_W-1:0] TOP_RST    = ROW_W'(FRAME_HEIGHT / 10);
  localparam logic [COL_W-1:0] RIGHT_RST  = COL_W'(FRAME_WIDTH - FRAME_WIDTH / 10);
  localparam logic [ROW_W-1:0] BOTTOM_RST = ROW_W'(FRAME_HEIGHT - FRAME_HEIGHT / 10);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_EMIT  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_SETUP,
    ST_AVG_RUN,
    ST_GAIN_SETUP,
    ST_GAIN_RUN
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } ffgm_req_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              in_zone;
  } ffgm_res_t;

  typedef struct packed {
    logic              in_zone;
    logic              empty;
    logic [AREA_W-1:0] area;
    logic              written;
  } zone_info_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
    logic [CNT_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic             overflow;
  } div_rsp_t;

endpackage

@@ rtl/flat_field_gain_map.sv @@
// Flat-field gain map builder. Issue a request with start while busy is low.
// Action clear and action accumulate finish in the accepting cycle and leave
// busy low, so they may be issued on every clock. Action emit raises busy and
// answers with exactly one result, shown on res_o for a single cycle with
// result_valid_o high; the receiver must take it then, as it cannot stall.
// In-zone results come from a bit-serial restoring divider that yields one
// quotient bit per cycle. A pixel outside the zone gets unity gain from the
// gain setup state with no gain divide. A pixel inside the zone with the zone
// average already known passes the gain setup state and a divide of 32 gain
// steps. The first emit after a clear, an accumulate or a register write
// first recomputes the average with a divide of 46 divider steps; an empty
// zone skips that divide. Register writes are allowed only while busy is low.
module flat_field_gain_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ffgm_pkg::ffgm_req_t        req_i,
  output logic                       result_valid_o,
  output ffgm_pkg::ffgm_res_t        res_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ffgm_pkg::CFG_W-1:0] cfg_data_i
);
  import ffgm_pkg::*;

  state_e            state_q, state_d;
  zone_info_t        zone;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              accept;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_q;
  logic [AVG_W-1:0]  avg_q;
  logic              ready_q;
  logic [PIX_W-1:0]  pix_q;
  logic              inside_q;
  logic              avg_load, avg_zero, emit_outside, emit_div;
  logic              valid_q;
  ffgm_res_t         res_q;
  logic [PIX_W-1:0]  pix_live;
  logic [AREA_W-1:0] pix_plus_one;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Only the low PIXEL_BITS bits of the pixel take part.
  assign pix_live = PIX_W'(req_i.pixel_value[PIXEL_BITS-1:0]);

  ffgm_zone u_zone (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .column_i   (req_i.column),
    .row_i      (req_i.row),
    .info_o     (zone)
  );

  ffgm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.action == ACT_EMIT)) state_d = ST_AVG_SETUP;
      end
      ST_AVG_SETUP: begin
        if (ready_q || zone.empty) state_d = ST_GAIN_SETUP;
        else                       state_d = ST_AVG_RUN;
      end
      ST_AVG_RUN: begin
        if (div_rsp.done) state_d = ST_GAIN_SETUP;
      end
      ST_GAIN_SETUP: begin
        if (inside_q) state_d = ST_GAIN_RUN;
        else          state_d = ST_IDLE;
      end
      ST_GAIN_RUN: begin
        if (div_rsp.done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pix_plus_one = AREA_W'(pix_q) + AREA_W'(1);

  // State outputs: divider requests and result events.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {sum_q, {AVG_FRAC{1'b0}}};
    div_req.divisor  = zone.area;
    div_req.steps    = DIV_STEPS_AVG;
    avg_load         = 1'b0;
    avg_zero         = 1'b0;
    emit_outside     = 1'b0;
    emit_div         = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_AVG_SETUP: begin
        if (!ready_q) begin
          if (zone.empty) avg_zero = 1'b1;
          else            div_req.start = 1'b1;
        end
      end
      ST_AVG_RUN: begin
        avg_load = div_rsp.done;
      end
      ST_GAIN_SETUP: begin
        if (inside_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = {avg_q, {(DVD_W - AVG_W){1'b0}}};
          div_req.divisor  = pix_plus_one;
          div_req.steps    = DIV_STEPS_GAIN;
        end else begin
          emit_outside = 1'b1;
        end
      end
      ST_GAIN_RUN: begin
        emit_div = div_rsp.done;
      end
      default: ;
    endcase
  end

  // Saturating accumulate of an in-zone pixel.
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(pix_live);

  // State, result valid, accumulator, average and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      avg_q   <= '0;
      ready_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= emit_outside || emit_div;
      priority if (accept && (req_i.action == ACT_CLEAR)) begin
        sum_q   <= '0;
        avg_q   <= '0;
        ready_q <= 1'b0;
      end else if (accept && (req_i.action == ACT_ACCUM)) begin
        if (zone.in_zone) begin
          sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        end
        ready_q <= 1'b0;
      end else if (avg_load) begin
        avg_q   <= (div_rsp.overflow || (div_rsp.quotient[QUO_W-1:AVG_W] != '0)) ?
                   AVG_MAX : div_rsp.quotient[AVG_W-1:0];
        ready_q <= 1'b1;
      end else if (avg_zero) begin
        avg_q   <= '0;
        ready_q <= 1'b1;
      end else if (zone.written) begin
        ready_q <= 1'b0;
      end
    end
  end

  // Captured emit request and the result register.
  always_ff @(posedge clk_i) begin
    if (accept && (req_i.action == ACT_EMIT)) begin
      pix_q    <= pix_live;
      inside_q <= zone.in_zone;
    end
    if (emit_outside) begin
      res_q.gain    <= GAIN_ONE;
      res_q.in_zone <= 1'b0;
    end else if (emit_div) begin
      res_q.gain    <= div_rsp.quotient;
      res_q.in_zone <= 1'b1;
    end
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule

@@ rtl/ffgm_zone.sv @@
module ffgm_zone (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ffgm_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [ffgm_pkg::COL_W-1:0] column_i,
  input  logic [ffgm_pkg::ROW_W-1:0] row_i,
  output ffgm_pkg::zone_info_t       info_o
);
  import ffgm_pkg::*;

  logic [COL_W-1:0] left_q, right_q;
  logic [ROW_W-1:0] top_q, bottom_q;
  logic [COL_W-1:0] width_w;
  logic [ROW_W-1:0] height_w;
  logic             empty_w;

  // Zone bound registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= LEFT_RST;
      top_q    <= TOP_RST;
      right_q  <= RIGHT_RST;
      bottom_q <= BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT:   left_q   <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i[ROW_W-1:0];
        CFG_RIGHT:  right_q  <= cfg_data_i;
        CFG_BOTTOM: bottom_q <= cfg_data_i[ROW_W-1:0];
        default:    left_q   <= left_q;
      endcase
    end
  end

  // Extent of the zone; only meaningful when the zone is not empty.
  assign empty_w  = (right_q <= left_q) || (bottom_q <= top_q);
  assign width_w  = right_q - left_q;
  assign height_w = bottom_q - top_q;

  // Membership test, area and write notice for the control logic.
  always_comb begin
    info_o.in_zone = (column_i >= left_q) && (column_i < right_q) &&
                     (row_i >= top_q) && (row_i < bottom_q);
    info_o.empty   = empty_w;
    info_o.area    = AREA_W'(width_w) * AREA_W'(height_w);
    info_o.written = cfg_we_i;
  end

endmodule

@@ rtl/ffgm_divider.sv @@
module ffgm_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffgm_pkg::div_req_t req_i,
  output ffgm_pkg::div_rsp_t rsp_o
);
  import ffgm_pkg::*;

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [AREA_W-1:0] dsr_q;
  logic [AREA_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [AREA_W:0]   trial;
  logic [AREA_W+1:0] diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign fits  = !diff[AREA_W+1];

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      rem_d = '0;
      quo_d = '0;
      ovf_d = 1'b0;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = fits ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
      quo_d  = {quo_q[QUO_W-2:0], fits};
      // A bit leaving the top of the quotient register marks an overflow.
      ovf_d  = ovf_q | quo_q[QUO_W-1];
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.overflow = ovf_q;

endmodule

@@ rtl/ffgm_checker.sv @@
`include "assert_macros.svh"

module ffgm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input ffgm_pkg::ffgm_req_t req_i,
  input logic                result_valid_o,
  input ffgm_pkg::ffgm_res_t res_o
);
  import ffgm_pkg::*;

  logic emit_accept;
  logic outside_result;
  logic unity_gain;

  // Terms shared by the properties below.
  assign emit_accept    = start && !busy && (req_i.action == ACT_EMIT);
  assign outside_result = result_valid_o && !res_o.in_zone;
  assign unity_gain     = (res_o.gain == GAIN_ONE);

  // An accepted emit request makes the block busy in the next cycle.
  `ASSERT_NEXT(emit_sets_busy, clk_i, rst_ni, emit_accept, busy, "emit did not raise busy")

  // A result follows a busy cycle; clear and accumulate never answer.
  `ASSERT_SAME(result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy), "stray result")

  // Results are single-cycle events with gaps between them.
  `ASSERT_NEXT(result_one_cycle, clk_i, rst_ni, result_valid_o, !result_valid_o, "strobe held")

  // A pixel outside the zone always gets unity gain.
  `ASSERT_SAME(outside_unity, clk_i, rst_ni, outside_result, unity_gain, "outside gain not unity")

endmodule

bind flat_field_gain_map ffgm_checker u_ffgm_checker (.*);
